FILE: rtl/i2r_pkg.sv
// Shared types, constants and digit tables for the integer to Roman numeral converter.
package i2r_pkg;

  localparam int VALUE_W  = 14;
  localparam int DIGITS   = 4;
  localparam int CNT_W    = $clog2(VALUE_W + 1);
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  localparam logic [VALUE_W-1:0] VALUE_MAX = VALUE_W'(9999);

  // Symbol codes
  localparam logic [2:0] SYM_I = 3'd0;
  localparam logic [2:0] SYM_V = 3'd1;
  localparam logic [2:0] SYM_X = 3'd2;
  localparam logic [2:0] SYM_L = 3'd3;
  localparam logic [2:0] SYM_C = 3'd4;
  localparam logic [2:0] SYM_D = 3'd5;
  localparam logic [2:0] SYM_M = 3'd6;

  // Digit positions, most significant first
  localparam logic [1:0] POS_THOU = 2'd0;
  localparam logic [1:0] POS_HUND = 2'd1;
  localparam logic [1:0] POS_TENS = 2'd2;
  localparam logic [1:0] POS_UNIT = 2'd3;

  // One converted item: digit 3 is thousands, digit 0 is units.
  typedef struct packed {
    logic                  err;
    logic [DIGITS-1:0][3:0] dig;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } q_port_t;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_CONV = 3'b010,
    F_PUSH = 3'b100
  } front_state_t;

  // Symbol count of one decimal digit in standard form.
  function automatic logic [3:0] digit_len(input logic [3:0] d);
    logic [3:0] n;
    case (d)
      4'd0:    n = 4'd0;
      4'd1:    n = 4'd1;
      4'd2:    n = 4'd2;
      4'd3:    n = 4'd3;
      4'd4:    n = 4'd2;
      4'd5:    n = 4'd1;
      4'd6:    n = 4'd2;
      4'd7:    n = 4'd3;
      4'd8:    n = 4'd4;
      4'd9:    n = 4'd2;
      default: n = 4'd0;
    endcase
    return n;
  endfunction

  // Symbol k of digit d, where base is the "one" symbol of that decade.
  function automatic logic [2:0] digit_sym(input logic [3:0] d, input logic [3:0] k,
                                           input logic [2:0] base);
    logic [2:0] s;
    case (d)
      4'd1, 4'd2, 4'd3:       s = base;
      4'd4:                   s = (k == 4'd0) ? base : base + 3'd1;
      4'd5, 4'd6, 4'd7, 4'd8: s = (k == 4'd0) ? base + 3'd1 : base;
      4'd9:                   s = (k == 4'd0) ? base : base + 3'd2;
      default:                s = base;
    endcase
    return s;
  endfunction

  function automatic logic [2:0] pos_base(input logic [1:0] pos);
    logic [2:0] b;
    case (pos)
      POS_HUND: b = SYM_C;
      POS_TENS: b = SYM_X;
      POS_UNIT: b = SYM_I;
      default:  b = SYM_M;
    endcase
    return b;
  endfunction

endpackage

FILE: rtl/i2r_front.sv
// Front end: accept a value, range check it and convert it to decimal digits.
module i2r_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [i2r_pkg::VALUE_W-1:0]   value,
  input  logic                          q_full,
  output i2r_pkg::q_port_t              push
);

  i2r_pkg::front_state_t state, state_next;

  logic [i2r_pkg::VALUE_W-1:0]     sh;
  logic [i2r_pkg::DIGITS*4-1:0]    bcd;
  logic [i2r_pkg::DIGITS*4-1:0]    bcd_adj;
  logic [i2r_pkg::CNT_W-1:0]       cnt;
  logic                            err;
  logic                            accept;

  assign in_ready = (state == i2r_pkg::F_IDLE);
  assign accept   = in_valid && in_ready;

  // Shift-and-add-3: correct each digit before the shift.
  always_comb begin
    for (int i = 0; i < i2r_pkg::DIGITS; i++) begin
      bcd_adj[i*4 +: 4] = (bcd[i*4 +: 4] >= 4'd5) ? bcd[i*4 +: 4] + 4'd3 : bcd[i*4 +: 4];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      i2r_pkg::F_IDLE: begin
        if (accept) begin
          state_next = (value == '0 || value > i2r_pkg::VALUE_MAX) ? i2r_pkg::F_PUSH
                                                                   : i2r_pkg::F_CONV;
        end
      end
      i2r_pkg::F_CONV: begin
        if (cnt == i2r_pkg::CNT_W'(i2r_pkg::VALUE_W - 1)) begin
          state_next = i2r_pkg::F_PUSH;
        end
      end
      i2r_pkg::F_PUSH: begin
        if (!q_full) begin
          state_next = i2r_pkg::F_IDLE;
        end
      end
      default: state_next = i2r_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= i2r_pkg::F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sh  <= value;
      bcd <= '0;
      cnt <= '0;
      err <= (value == '0) || (value > i2r_pkg::VALUE_MAX);
    end else if (state == i2r_pkg::F_CONV) begin
      bcd <= {bcd_adj[i2r_pkg::DIGITS*4-2:0], sh[i2r_pkg::VALUE_W-1]};
      sh  <= {sh[i2r_pkg::VALUE_W-2:0], 1'b0};
      cnt <= cnt + i2r_pkg::CNT_W'(1);
    end
  end

  always_comb begin
    push.valid     = (state == i2r_pkg::F_PUSH) && !q_full;
    push.entry.err = err;
    push.entry.dig = bcd;
  end

endmodule

FILE: rtl/i2r_queue.sv
// Small register queue of converted items between front and back.
module i2r_queue (
  input  logic              clk,
  input  logic              rst,
  input  i2r_pkg::q_port_t  push,
  output logic              full,
  input  logic              pop,
  output i2r_pkg::q_port_t  head
);

  i2r_pkg::entry_t             mem [i2r_pkg::QDEPTH];
  logic [i2r_pkg::QPTR_W-1:0]  wr_ptr;
  logic [i2r_pkg::QPTR_W-1:0]  rd_ptr;
  logic [i2r_pkg::QCNT_W-1:0]  count;
  logic                        do_push;
  logic                        do_pop;

  assign full    = (count == i2r_pkg::QCNT_W'(i2r_pkg::QDEPTH));
  assign do_push = push.valid && !full;
  assign do_pop  = pop && (count != '0);

  always_comb begin
    head.valid = (count != '0);
    head.entry = mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == i2r_pkg::QPTR_W'(i2r_pkg::QDEPTH - 1)) ? '0
                                                                  : wr_ptr + i2r_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == i2r_pkg::QPTR_W'(i2r_pkg::QDEPTH - 1)) ? '0
                                                                  : rd_ptr + i2r_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + i2r_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - i2r_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

FILE: rtl/i2r_back.sv
// Back end: walk the digits of one item and emit its symbols through an output register.
module i2r_back (
  input  logic              clk,
  input  logic              rst,
  input  i2r_pkg::q_port_t  head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        symbol,
  output logic              last,
  output logic              error
);

  logic                              busy;
  logic [i2r_pkg::DIGITS-1:0][3:0]   dig;
  logic [1:0]                        pos;
  logic [3:0]                        k;

  logic        slot_free;
  logic [3:0]  d;
  logic [3:0]  len;
  logic        rest_zero;
  logic        emit;
  logic        fin_digit;
  logic        fin_item;
  logic [2:0]  sym;

  assign slot_free = !out_valid || out_ready;
  // Error items go straight to the output register, so they also need the slot.
  assign pop       = !busy && head.valid && (!head.entry.err || slot_free);

  always_comb begin
    d   = dig[~pos];
    len = (pos == i2r_pkg::POS_THOU) ? d : i2r_pkg::digit_len(d);
    sym = (pos == i2r_pkg::POS_THOU) ? i2r_pkg::SYM_M
                                     : i2r_pkg::digit_sym(d, k, i2r_pkg::pos_base(pos));
    case (pos)
      i2r_pkg::POS_THOU: rest_zero = (dig[2] == '0) && (dig[1] == '0) && (dig[0] == '0);
      i2r_pkg::POS_HUND: rest_zero = (dig[1] == '0) && (dig[0] == '0);
      i2r_pkg::POS_TENS: rest_zero = (dig[0] == '0);
      default:           rest_zero = 1'b1;
    endcase
    emit      = busy && slot_free && (k < len);
    fin_digit = (k == len - 4'd1);
    fin_item  = fin_digit && rest_zero;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (pop && !head.entry.err) begin
      busy <= 1'b1;
    end else if (emit && fin_item) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      dig <= head.entry.dig;
      pos <= i2r_pkg::POS_THOU;
      k   <= '0;
    end else if (busy && slot_free) begin
      if (!emit || fin_digit) begin
        pos <= pos + 2'd1;
        k   <= '0;
      end else begin
        k <= k + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit || (pop && head.entry.err)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.entry.err) begin
      symbol <= i2r_pkg::SYM_I;
      last   <= 1'b1;
      error  <= 1'b1;
    end else if (emit) begin
      symbol <= sym;
      last   <= fin_item;
      error  <= 1'b0;
    end
  end

endmodule

FILE: rtl/integer_to_roman_symbols.sv
// Top level of the integer to Roman numeral symbol stream converter.
//
// Input channel (in_valid/in_ready/value): one 14-bit binary value per transfer.
// Output channel (out_valid/out_ready/symbol/last/error): one Roman symbol per
// transfer, most significant decimal digit first, last high on the final
// symbol of a numeral. Codes: 0=I 1=V 2=X 3=L 4=C 5=D 6=M.
// A value of 0 or above 9999 yields one transfer with error, last high, symbol 0.
// Path: a valid value runs through the shift-and-add-3 converter of the front
// end, enters the queue and is popped by the back end, whose output register
// then shows its first symbol on out_valid. Out of range values skip the
// converter and go from the front end straight into the queue.
// The front end takes no new value until it has pushed the last one; the
// converter is a one-bit-per-cycle binary to decimal loop. The back end emits
// one symbol per cycle while its output register is free, besides stepping past
// each zero digit and popping each item; a numeral has 21 symbols at most.
// A two-entry queue between the two lets the front convert the next value
// while the back still drains symbols.
// Stalls: while out_ready is low the output register holds its symbol and the
// back end holds its place; the queue then fills and in_ready drops.
// Reset (rst, synchronous) empties the queue, idles both ends and drops out_valid.
module integer_to_roman_symbols (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [i2r_pkg::VALUE_W-1:0]  value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [2:0]                   symbol,
  output logic                         last,
  output logic                         error
);

  i2r_pkg::q_port_t push;
  i2r_pkg::q_port_t head;
  logic             q_full;
  logic             pop;

  // Accept, range check and convert to decimal digits
  i2r_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .value    (value),
    .q_full   (q_full),
    .push     (push)
  );

  // Decouple conversion from symbol emission
  i2r_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (q_full),
    .pop  (pop),
    .head (head)
  );

  // Emit symbols, one per cycle while the output register is free, into the output register
  i2r_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .symbol    (symbol),
    .last      (last),
    .error     (error)
  );

endmodule

FILE: rtl/i2r_checker.sv
// Port-level checks for the Roman symbol converter, bound to the top level.
module i2r_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [i2r_pkg::VALUE_W-1:0]  value,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [2:0]                   symbol,
  input logic                         last,
  input logic                         error
);

  a_rst_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> last && (symbol == i2r_pkg::SYM_I))
    else $error("error result not a single symbol-0 last transfer");

  a_sym_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (symbol <= i2r_pkg::SYM_M))
    else $error("symbol code out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(symbol) && $stable(last) && $stable(error))
    else $error("stalled output changed");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(value))
    else $error("stalled input changed");

endmodule

bind integer_to_roman_symbols i2r_checker u_i2r_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .value     (value),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .symbol    (symbol),
  .last      (last),
  .error     (error)
);

FILE: tb/tb_integer_to_roman_symbols.sv
// Self-checking testbench for the integer to Roman numeral symbol stream converter.
module tb_integer_to_roman_symbols;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT     = 1_000_000;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned SETTLE_CYCLES   = 40;
  localparam int unsigned REPORT_CAP      = 50;

  typedef logic [i2r_pkg::VALUE_W-1:0] value_t;

  // One expected output transfer.
  typedef struct {
    logic [2:0] symbol;
    logic       last;
    logic       error;
  } roman_sym_t;

  // Holds the symbols still owed by the block, oldest first, and grades each output transfer.
  class numeral_board;
    roman_sym_t  owed[$];
    int unsigned failures;

    function int unsigned pending();
      return owed.size();
    endfunction

    function void flag(string what, logic [2:0] exp_v, logic [2:0] got_v);
      failures++;
      if (failures <= REPORT_CAP)
        $error("%s: expected %0d, actual %0d", what, exp_v, got_v);
    endfunction

    // Spell one decimal digit in standard form, subtractive for 4 and 9.
    function void spell_digit(ref roman_sym_t run[$], input int unsigned d,
                              input logic [2:0] one, input logic [2:0] five,
                              input logic [2:0] ten);
      roman_sym_t s;
      s.last  = 1'b0;
      s.error = 1'b0;
      case (d)
        1, 2, 3: begin
          s.symbol = one;
          repeat (d) run.push_back(s);
        end
        4: begin
          s.symbol = one;
          run.push_back(s);
          s.symbol = five;
          run.push_back(s);
        end
        5, 6, 7, 8: begin
          s.symbol = five;
          run.push_back(s);
          s.symbol = one;
          repeat (d - 5) run.push_back(s);
        end
        9: begin
          s.symbol = one;
          run.push_back(s);
          s.symbol = ten;
          run.push_back(s);
        end
        default: ;
      endcase
    endfunction

    // Queue the symbols that one accepted value must produce.
    function void note_value(value_t v);
      roman_sym_t  run[$];
      roman_sym_t  s;
      int unsigned n;
      n = v;
      if (n == 0 || n > 9999) begin
        s.symbol = i2r_pkg::SYM_I;
        s.last   = 1'b1;
        s.error  = 1'b1;
        owed.push_back(s);
        return;
      end
      s.symbol = i2r_pkg::SYM_M;
      s.last   = 1'b0;
      s.error  = 1'b0;
      repeat (n / 1000) run.push_back(s);
      spell_digit(run, (n / 100) % 10, i2r_pkg::SYM_C, i2r_pkg::SYM_D, i2r_pkg::SYM_M);
      spell_digit(run, (n / 10) % 10, i2r_pkg::SYM_X, i2r_pkg::SYM_L, i2r_pkg::SYM_C);
      spell_digit(run, n % 10, i2r_pkg::SYM_I, i2r_pkg::SYM_V, i2r_pkg::SYM_X);
      run[run.size() - 1].last = 1'b1;
      foreach (run[i]) owed.push_back(run[i]);
    endfunction

    // Compare one output transfer with the oldest owed symbol.
    function void check_symbol(logic [2:0] sym, logic lst, logic err);
      roman_sym_t e;
      if (owed.size() == 0) begin
        failures++;
        if (failures <= REPORT_CAP)
          $error("unexpected transfer: symbol %0d last %0b error %0b", sym, lst, err);
        return;
      end
      e = owed.pop_front();
      if (sym !== e.symbol) flag("symbol", e.symbol, sym);
      if (lst !== e.last) flag("last", 3'(e.last), 3'(lst));
      if (err !== e.error) flag("error", 3'(e.error), 3'(err));
    endfunction
  endclass

  // Every input starts at a known level; reset is high from time zero.
  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  value_t     value     = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] symbol;
  logic       last;
  logic       error;

  numeral_board board = new();
  int unsigned  cycle_count = 0;

  // Control between the sender and the receiver process.
  bit hold_off_req   = 1'b0;
  bit ready_free_run = 1'b0;

  integer_to_roman_symbols uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .symbol    (symbol),
    .last      (last),
    .error     (error)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Random value: mostly in range with a spread of magnitudes, some out of range, some raw.
  function automatic value_t pick_value();
    int unsigned r = $urandom_range(99);
    if (r < 5)  return value_t'($urandom_range(16383, 0));
    if (r < 9)  return '0;
    if (r < 15) return value_t'($urandom_range(16383, 10000));
    if (r < 30) return value_t'($urandom_range(99, 1));
    if (r < 50) return value_t'($urandom_range(999, 1));
    return value_t'($urandom_range(9999, 1));
  endfunction

  // Offer one value after an optional idle gap; return at the falling edge after the transfer.
  // Valid stays high with no gap, so back-to-back transfers never drop it.
  task automatic send_value(input value_t v, input int unsigned gap);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_value(v);
    @(negedge clk);
  endtask

  // Drop valid and wait for every owed symbol to come out.
  task automatic drain_numerals();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Receiver: random stalls, a free-running phase, and one long hold-off on request.
  initial begin
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off_req) begin
        // Hold off long enough for the queue to fill and in_ready to drop.
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end else if (ready_free_run) begin
        out_ready <= 1'b1;
        @(negedge clk);
      end else begin
        int unsigned stall;
        stall = pick_gap();
        if (stall != 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
        out_ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // Grade every output transfer at the rising edge.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      board.check_symbol(symbol, last, error);
  end

  // Watchdog: end the run if it overstays the limit.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_integer_to_roman_symbols failed");
    $finish;
  end

  initial begin
    value_t directed[$];

    // Hold reset, then release it on a falling edge.
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: field extremes, out of range values, long numerals,
    // many digit values in each position, subtractive pairs.
    directed = '{14'd1, 14'd9999, 14'd0, 14'd10000, 14'd16383, 14'd8888, 14'd3999,
                 14'd4, 14'd9, 14'd40, 14'd90, 14'd400, 14'd900, 14'd1994, 14'd2468,
                 14'd1000, 14'd5, 14'd50, 14'd500, 14'd3888, 14'd9000, 14'd9444,
                 14'd7777, 14'd6666, 14'd8192};
    foreach (directed[i]) send_value(directed[i], pick_gap());

    // Pause the sender until the block has emptied.
    drain_numerals();

    // Stall the receiver for a long stretch while long numerals keep coming.
    hold_off_req = 1'b1;
    repeat (14) send_value(value_t'($urandom_range(9999, 7000)), 0);
    drain_numerals();

    // No idling on either side for a stretch.
    ready_free_run = 1'b1;
    repeat (30) send_value(pick_value(), 0);
    drain_numerals();
    ready_free_run = 1'b0;

    // Random values with random gaps, one drain in the middle.
    repeat (60) send_value(pick_value(), pick_gap());
    drain_numerals();
    repeat (30) send_value(pick_value(), pick_gap());

    drain_numerals();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (board.failures == 0 && board.pending() == 0)
      $display("tb_integer_to_roman_symbols passed");
    else
      $display("tb_integer_to_roman_symbols failed");
    $finish;
  end

endmodule
